[rtl/sha1bc_pkg.sv]
// SHA-1 block compression: shared types, constants and round functions.
// No dependencies; used by every module of the block.
`default_nettype none
package sha1bc_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned NumCv    = 5;
  localparam int unsigned NumRound = 80;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic [31:0] message_word;
    logic        final_block;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  // Control from the sequencer to the round datapath
  typedef struct packed {
    logic       load;    // copy chaining value into working registers
    logic       round;   // run one round
    logic [1:0] phase;   // which twenty-round group
    logic       add;     // fold working registers into chaining value
    logic       reinit;  // return chaining value to the initial value
  } ctrl_t;

  localparam word_t Iv [NumCv] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  function automatic word_t round_k(input logic [1:0] phase);
    word_t k;
    unique case (phase)
      2'd0:    k = 32'h5A827999;
      2'd1:    k = 32'h6ED9EBA1;
      2'd2:    k = 32'h8F1BBCDC;
      default: k = 32'hCA62C1D6;
    endcase
    return k;
  endfunction

  function automatic word_t round_f(input logic [1:0] phase, input word_t b,
                                    input word_t c, input word_t d);
    word_t f;
    unique case (phase)
      2'd0:    f = (b & c) | (~b & d);
      2'd2:    f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

[rtl/sha1_block_compression.sv]
// Words 1 to 15 of a block are taken one per cycle with busy low. The
// sixteenth word holds busy through the 80 rounds on the shared round adder and
// the chaining add, and on a final block also through the emit state that sends
// the five digest strobes, first word first; the next block's words wait until
// busy falls, and the receiver cannot stall. Synchronous active-low
// reset loads the initial chaining value and clears the word position.
`default_nettype none
module sha1_block_compression (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire sha1bc_pkg::in_t   in_data,
  output logic                   busy,
  output logic                   out_valid,
  output sha1bc_pkg::out_t       out_data
);

  sha1bc_pkg::state_t state_r, state_nxt;
  logic [3:0]         pos_r;
  logic [6:0]         rcnt_r;
  logic [2:0]         ecnt_r;
  logic               final_r;
  logic               out_valid_r;
  sha1bc_pkg::out_t   out_data_r;

  logic               accept;
  logic               emit;
  sha1bc_pkg::ctrl_t  ctrl;
  sha1bc_pkg::word_t  w;
  sha1bc_pkg::word_t  cv_word;

  assign busy      = (state_r != sha1bc_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sha1bc_pkg::ST_IDLE:
        if (accept && pos_r == 4'd15) state_nxt = sha1bc_pkg::ST_ROUND;
      sha1bc_pkg::ST_ROUND:
        if (rcnt_r == 7'(sha1bc_pkg::NumRound - 1)) state_nxt = sha1bc_pkg::ST_ADD;
      sha1bc_pkg::ST_ADD:
        state_nxt = final_r ? sha1bc_pkg::ST_EMIT : sha1bc_pkg::ST_IDLE;
      sha1bc_pkg::ST_EMIT:
        if (ecnt_r == 3'(sha1bc_pkg::NumCv - 1)) state_nxt = sha1bc_pkg::ST_IDLE;
      default:
        state_nxt = sha1bc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl        = '0;
    emit        = 1'b0;
    ctrl.load   = accept && (pos_r == 4'd15);
    ctrl.round  = (state_r == sha1bc_pkg::ST_ROUND);
    ctrl.add    = (state_r == sha1bc_pkg::ST_ADD);
    emit        = (state_r == sha1bc_pkg::ST_EMIT);
    ctrl.reinit = emit && (ecnt_r == 3'(sha1bc_pkg::NumCv - 1));
    priority if (rcnt_r < 7'd20) ctrl.phase = 2'd0;
    else if (rcnt_r < 7'd40)      ctrl.phase = 2'd1;
    else if (rcnt_r < 7'd60)      ctrl.phase = 2'd2;
    else                          ctrl.phase = 2'd3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha1bc_pkg::ST_IDLE;
      pos_r       <= '0;
      rcnt_r      <= '0;
      ecnt_r      <= '0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
      if (accept) begin
        pos_r <= pos_r + 4'd1;
        if (pos_r == 4'd15) final_r <= in_data.final_block;
      end
      rcnt_r <= ctrl.round ? rcnt_r + 7'd1 : '0;
      ecnt_r <= emit ? ecnt_r + 3'd1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.digest_word <= cv_word;
      out_data_r.digest_last <= (ecnt_r == 3'(sha1bc_pkg::NumCv - 1));
    end
  end

  sha1bc_sched u_sched (
    .clk      (clk),
    .shift_in (accept),
    .word_in  (in_data.message_word),
    .advance  (ctrl.round),
    .w_out    (w)
  );

  sha1bc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .w_in    (w),
    .cv_sel  (ecnt_r),
    .cv_word (cv_word)
  );

`ifndef SYNTHESIS
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == sha1bc_pkg::ST_EMIT))
    else $error("digest strobe without emit state");

  a_block_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && pos_r == 4'd15) |=> (state_r == sha1bc_pkg::ST_ROUND && rcnt_r == 7'd0))
    else $error("sixteenth word did not start rounds");

  a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha1bc_pkg::ST_ROUND && rcnt_r == 7'd79) |=> state_r == sha1bc_pkg::ST_ADD)
    else $error("round sequence did not end after 80 rounds");

  a_last_marks_fifth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.digest_last) |-> $past(ecnt_r == 3'd4))
    else $error("last flag on wrong digest word");
`endif

endmodule
`default_nettype wire

[rtl/sha1bc_sched.sv]
// SHA-1 message schedule: sixteen-word sliding window as a shift line.
// Depends on sha1bc_pkg for the word type.
`default_nettype none
module sha1bc_sched (
  input  wire logic              clk,
  input  wire logic              shift_in,
  input  wire sha1bc_pkg::word_t word_in,
  input  wire logic              advance,
  output sha1bc_pkg::word_t      w_out
);

  sha1bc_pkg::word_t win_r [16];
  sha1bc_pkg::word_t expand;
  sha1bc_pkg::word_t mix;

  // window holds W[t..t+15]; next schedule word from fixed taps
  assign mix    = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign expand = {mix[30:0], mix[31]};
  assign w_out  = win_r[0];

  always_ff @(posedge clk) begin
    if (shift_in || advance) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= shift_in ? word_in : expand;
    end
  end

endmodule
`default_nettype wire

[rtl/sha1bc_core.sv]
// SHA-1 round datapath: working registers a..e, one shared round adder,
// and the five-word chaining value. Depends on sha1bc_pkg.
`default_nettype none
module sha1bc_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sha1bc_pkg::ctrl_t ctrl,
  input  wire sha1bc_pkg::word_t w_in,
  input  wire logic [2:0]        cv_sel,
  output sha1bc_pkg::word_t      cv_word
);

  sha1bc_pkg::word_t cv_r [sha1bc_pkg::NumCv];
  sha1bc_pkg::word_t a_r, b_r, c_r, d_r, e_r;
  sha1bc_pkg::word_t temp;

  assign temp = {a_r[26:0], a_r[31:27]}
              + sha1bc_pkg::round_f(ctrl.phase, b_r, c_r, d_r)
              + e_r + sha1bc_pkg::round_k(ctrl.phase) + w_in;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a_r <= cv_r[0];
      b_r <= cv_r[1];
      c_r <= cv_r[2];
      d_r <= cv_r[3];
      e_r <= cv_r[4];
    end else if (ctrl.round) begin
      a_r <= temp;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.reinit) begin
      for (int i = 0; i < sha1bc_pkg::NumCv; i++) begin
        cv_r[i] <= sha1bc_pkg::Iv[i];
      end
    end else if (ctrl.add) begin
      cv_r[0] <= cv_r[0] + a_r;
      cv_r[1] <= cv_r[1] + b_r;
      cv_r[2] <= cv_r[2] + c_r;
      cv_r[3] <= cv_r[3] + d_r;
      cv_r[4] <= cv_r[4] + e_r;
    end
  end

  always_comb begin
    unique case (cv_sel)
      3'd0:    cv_word = cv_r[0];
      3'd1:    cv_word = cv_r[1];
      3'd2:    cv_word = cv_r[2];
      3'd3:    cv_word = cv_r[3];
      default: cv_word = cv_r[4];
    endcase
  end

endmodule
`default_nettype wire

[dv/tb_sha1_block_compression.sv]
// Testbench for the SHA-1 block compression engine: streams message
// words, predicts digests with its own SHA-1 model and checks every digest word.
// Depends on sha1bc_pkg and sha1_block_compression from the rtl folder.
module tb_sha1_block_compression;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit   = 1000;
  localparam int DrainCycles = 100;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  sha1bc_pkg::in_t      in_data;
  logic                 busy;
  logic                 out_valid;
  sha1bc_pkg::out_t     out_data;

  // Predicted engine state
  sha1bc_pkg::word_t    hash_state [5];
  sha1bc_pkg::word_t    blk_words [16];
  logic [3:0]           word_idx;
  sha1bc_pkg::out_t     digest_q [$];

  int unsigned          errors;
  int unsigned          items_sent;
  int unsigned          digests_expected;
  int unsigned          idle_cycles;

  sha1_block_compression DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run the 80 rounds over the buffered block and fold into the hash state.
  function automatic void fold_block();
    sha1bc_pkg::word_t sched [16];
    sha1bc_pkg::word_t va, vb, vc, vd, ve, w, f, k, t;
    for (int i = 0; i < 16; i++) sched[i] = blk_words[i];
    va = hash_state[0];
    vb = hash_state[1];
    vc = hash_state[2];
    vd = hash_state[3];
    ve = hash_state[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        w = sched[r];
      end else begin
        w = sched[(r + 13) % 16] ^ sched[(r + 8) % 16] ^ sched[(r + 2) % 16] ^ sched[r % 16];
        w = {w[30:0], w[31]};
        sched[r % 16] = w;
      end
      case (r / 20)
        0: begin
          f = (vb & vc) | (~vb & vd);
          k = 32'h5A827999;
        end
        1: begin
          f = vb ^ vc ^ vd;
          k = 32'h6ED9EBA1;
        end
        2: begin
          f = (vb & vc) | (vb & vd) | (vc & vd);
          k = 32'h8F1BBCDC;
        end
        default: begin
          f = vb ^ vc ^ vd;
          k = 32'hCA62C1D6;
        end
      endcase
      t  = {va[26:0], va[31:27]} + f + ve + k + w;
      ve = vd;
      vd = vc;
      vc = {vb[1:0], vb[31:2]};
      vb = va;
      va = t;
    end
    hash_state[0] += va;
    hash_state[1] += vb;
    hash_state[2] += vc;
    hash_state[3] += vd;
    hash_state[4] += ve;
  endfunction

  function automatic void restore_iv();
    for (int i = 0; i < 5; i++) hash_state[i] = sha1bc_pkg::Iv[i];
  endfunction

  // Buffer one accepted word; on a final sixteenth word queue the digest.
  function automatic void absorb_word(input sha1bc_pkg::in_t req);
    sha1bc_pkg::out_t dw;
    blk_words[word_idx] = req.message_word;
    if (word_idx != 4'd15) begin
      word_idx++;
      return;
    end
    word_idx = 4'd0;
    fold_block();
    if (req.final_block) begin
      for (int i = 0; i < 5; i++) begin
        dw.digest_word = hash_state[i];
        dw.digest_last = (i == 4);
        digest_q.push_back(dw);
        digests_expected++;
      end
      restore_iv();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input logic [31:0] word, input logic final_flag,
                           input bit gaps_on);
    sha1bc_pkg::in_t req;
    int gap;
    req.message_word = word;
    req.final_block  = final_flag;
    in_data <= req;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    absorb_word(req);
    items_sent++;
    gap = gaps_on ? draw_gap() : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_block(input bit last, input bit gaps_on);
    logic [31:0] word;
    int sel;
    for (int i = 0; i < 16; i++) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) word = '0;
      else if (sel == 1) word = '1;
      else word = $urandom;
      // final_block only matters on the sixteenth word; toggle it elsewhere
      send_word(word, (i == 15) ? last : 1'($urandom_range(0, 1)), gaps_on);
    end
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // Non-final block of extreme words, final_block raised on early words.
  task automatic test_word_extremes();
    sha1bc_pkg::word_t pattern [16];
    pattern = '{32'h00000000, 32'hFFFFFFFF, 32'h80000000, 32'h00000001,
                32'h7FFFFFFF, 32'hFFFFFFFE, 32'hAAAAAAAA, 32'h55555555,
                32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'h00000000,
                32'h0000FFFF, 32'hFFFF0000, 32'h12345678, 32'hFFFFFFFF};
    for (int i = 0; i < 16; i++)
      send_word(pattern[i], (i != 15) && (i % 2 == 1), 1'b1);
  endtask

  // Padded "abc" as the closing block of the message.
  task automatic test_single_block_message();
    for (int i = 0; i < 16; i++)
      send_word((i == 0) ? 32'h61626380 : (i == 15) ? 32'h00000018 : 32'h0,
                i == 15, 1'b1);
    wait_drain();
  endtask

  task automatic test_random_messages();
    int msg;
    int blocks;
    bit gaps_on;
    msg = 0;
    while (items_sent < 190 || digests_expected < 30) begin
      blocks  = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 2) : $urandom_range(3, 4);
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int b = 0; b < blocks; b++) send_random_block(b == blocks - 1, gaps_on);
      if (msg == 0 || $urandom_range(0, 3) == 0) wait_drain();
      msg++;
    end
  endtask

  // Back-to-back requests with no idle cycles on the sender.
  task automatic test_streaming_no_gaps();
    send_random_block(1'b1, 1'b0);
    send_random_block(1'b0, 1'b0);
    send_random_block(1'b1, 1'b0);
  endtask

  // Check each digest word against the oldest prediction; watch for a hang.
  always @(posedge clk) begin
    sha1bc_pkg::out_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (digest_q.size() == 0) begin
          report_mismatch("digest word with none pending", out_data.digest_word, '0);
        end else begin
          want = digest_q.pop_front();
          if (out_data.digest_word !== want.digest_word)
            report_mismatch("digest_word", out_data.digest_word, want.digest_word);
          if (out_data.digest_last !== want.digest_last)
            report_mismatch("digest_last", {31'b0, out_data.digest_last},
                            {31'b0, want.digest_last});
        end
      end
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    start            = 1'b0;
    in_data          = '0;
    errors           = 0;
    items_sent       = 0;
    digests_expected = 0;
    idle_cycles      = 0;
    word_idx         = 4'd0;
    restore_iv();
    for (int i = 0; i < 16; i++) blk_words[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_word_extremes();
    test_single_block_message();
    test_random_messages();
    test_streaming_no_gaps();

    wait_drain();
    repeat (DrainCycles) @(posedge clk);
    if (digest_q.size() != 0)
      report_mismatch("digest words never produced", 32'(digest_q.size()), '0);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/sha1bc_pkg.sv
rtl/sha1bc_sched.sv
rtl/sha1bc_core.sv
rtl/sha1_block_compression.sv
dv/tb_sha1_block_compression.sv
